// File: rtl/cap_pkg.sv
// Shared types and constants for the closest approach point pipeline.
package cap_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int DW            = 67;       // width of dv.dv, always non-negative
   localparam int SW            = 68;       // width of the signed dot-product sums
   localparam int QW            = 32;       // quotient bits
   localparam int RW            = DW + QW;  // width of the divider remainder
   localparam logic [31:0] THR_RESET = 32'd4295;

   typedef logic signed [32:0] cap_s33_type;

   typedef struct packed {
      logic signed [31:0] pos_a_x;
      logic signed [31:0] pos_a_y;
      logic signed [31:0] pos_a_z;
      logic signed [31:0] vel_a_x;
      logic signed [31:0] vel_a_y;
      logic signed [31:0] vel_a_z;
      logic signed [31:0] pos_b_x;
      logic signed [31:0] pos_b_y;
      logic signed [31:0] pos_b_z;
      logic signed [31:0] vel_b_x;
      logic signed [31:0] vel_b_y;
      logic signed [31:0] vel_b_z;
   } cap_req_type;

   typedef struct packed {
      logic               found;
      logic [31:0]        approach_time;
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic signed [31:0] point_z;
   } cap_rsp_type;

   // Per-axis sums of the two bodies, carried alongside the division.
   typedef struct packed {
      cap_s33_type [2:0] psum;
      cap_s33_type [2:0] vsum;
   } cap_ctx_type;

   typedef struct packed {
      logic [RW-1:0] rem;
      logic [DW-1:0] den;
      logic [QW-1:0] q;
      logic          go;
      logic          sat;
   } cap_div_type;

endpackage

// File: rtl/cap_front.sv
// Front pipeline: differences, dot products and the division setup.
module cap_front import cap_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        en,
   input  logic        in_valid,
   input  cap_req_type in_data,
   input  logic [31:0] thr,
   output logic        out_valid,
   output cap_div_type out_div,
   output cap_ctx_type out_ctx
);

   logic [3:0]         v_ff;
   cap_s33_type [2:0]  dp_ff, dv_ff, dp_in, dv_in;
   cap_ctx_type        c1_ff, c2_ff, c3_ff, c4_ff, c1_in;
   logic signed [65:0] pp_ff [3];
   logic signed [65:0] pd_ff [3];
   logic signed [SW-1:0] dvdv_ff, dpdv_ff, dvdv_in, dpdv_in;
   cap_div_type        div_ff, div_in;
   logic signed [SW-1:0] neg;
   logic [RW-1:0]      numx, densh;

   always_comb begin
      dp_in[0] = cap_s33_type'(in_data.pos_a_x) - cap_s33_type'(in_data.pos_b_x);
      dp_in[1] = cap_s33_type'(in_data.pos_a_y) - cap_s33_type'(in_data.pos_b_y);
      dp_in[2] = cap_s33_type'(in_data.pos_a_z) - cap_s33_type'(in_data.pos_b_z);
      dv_in[0] = cap_s33_type'(in_data.vel_a_x) - cap_s33_type'(in_data.vel_b_x);
      dv_in[1] = cap_s33_type'(in_data.vel_a_y) - cap_s33_type'(in_data.vel_b_y);
      dv_in[2] = cap_s33_type'(in_data.vel_a_z) - cap_s33_type'(in_data.vel_b_z);
      c1_in.psum[0] = cap_s33_type'(in_data.pos_a_x) + cap_s33_type'(in_data.pos_b_x);
      c1_in.psum[1] = cap_s33_type'(in_data.pos_a_y) + cap_s33_type'(in_data.pos_b_y);
      c1_in.psum[2] = cap_s33_type'(in_data.pos_a_z) + cap_s33_type'(in_data.pos_b_z);
      c1_in.vsum[0] = cap_s33_type'(in_data.vel_a_x) + cap_s33_type'(in_data.vel_b_x);
      c1_in.vsum[1] = cap_s33_type'(in_data.vel_a_y) + cap_s33_type'(in_data.vel_b_y);
      c1_in.vsum[2] = cap_s33_type'(in_data.vel_a_z) + cap_s33_type'(in_data.vel_b_z);
   end

   always_comb begin
      dvdv_in = '0;
      dpdv_in = '0;
      for (int i = 0; i < 3; i++) begin
         dvdv_in = dvdv_in + SW'(pp_ff[i]);
         dpdv_in = dpdv_in + SW'(pd_ff[i]);
      end
   end

   // The numerator is only used when dp.dv is negative, so its magnitude fits 66 bits.
   always_comb begin
      neg   = -dpdv_ff;
      numx  = {{(RW-66){1'b0}}, neg[65:0]} << FRAC_BITS;
      densh = {dvdv_ff[DW-1:0], {QW{1'b0}}};
      div_in.rem = numx;
      div_in.den = dvdv_ff[DW-1:0];
      div_in.q   = '0;
      div_in.go  = !(dvdv_ff[DW-1:0] < {{(DW-32){1'b0}}, thr}) && dpdv_ff[SW-1]
                   && (dvdv_ff != '0);
      div_in.sat = numx >= densh;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dp_ff <= dp_in;
         dv_ff <= dv_in;
         c1_ff <= c1_in;
         for (int i = 0; i < 3; i++) begin
            pp_ff[i] <= $signed(dv_ff[i]) * $signed(dv_ff[i]);
            pd_ff[i] <= $signed(dp_ff[i]) * $signed(dv_ff[i]);
         end
         c2_ff   <= c1_ff;
         dvdv_ff <= dvdv_in;
         dpdv_ff <= dpdv_in;
         c3_ff   <= c2_ff;
         div_ff  <= div_in;
         c4_ff   <= c3_ff;
      end
   end

   assign out_valid = v_ff[3];
   assign out_div   = div_ff;
   assign out_ctx   = c4_ff;

endmodule

// File: rtl/cap_div_stage.sv
// One restoring-division stage: settles one quotient bit.
module cap_div_stage import cap_pkg::*; #(
   parameter int BIT = 0
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        en,
   input  logic        in_valid,
   input  cap_div_type in_div,
   input  cap_ctx_type in_ctx,
   output logic        out_valid,
   output cap_div_type out_div,
   output cap_ctx_type out_ctx
);

   logic          valid_ff;
   cap_div_type   div_ff, div_in;
   cap_ctx_type   ctx_ff;
   logic [RW-1:0] d;
   logic          ge;

   always_comb begin
      d      = {{(RW-DW){1'b0}}, in_div.den} << BIT;
      ge     = in_div.rem >= d;
      div_in = in_div;
      if (ge) begin
         div_in.rem    = in_div.rem - d;
         div_in.q[BIT] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         div_ff <= div_in;
         ctx_ff <= in_ctx;
      end
   end

   assign out_valid = valid_ff;
   assign out_div   = div_ff;
   assign out_ctx   = ctx_ff;

endmodule

// File: rtl/cap_back.sv
// Back pipeline: final time, midpoint products and saturation.
module cap_back import cap_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        en,
   input  logic        in_valid,
   input  cap_div_type in_div,
   input  cap_ctx_type in_ctx,
   output logic        out_valid,
   output cap_rsp_type out_rsp
);

   logic               v1_ff, v2_ff;
   logic [31:0]        t_in, t_ff;
   logic               found_ff;
   cap_s33_type [2:0]  psum_ff;
   logic signed [65:0] prod_ff [3];
   logic signed [67:0] acc   [3];
   logic signed [67:0] sh    [3];
   logic [31:0]        pt    [3];
   cap_rsp_type        rsp_ff, rsp_in;

   always_comb begin
      if (!in_div.go) begin
         t_in = '0;
      end else if (in_div.sat) begin
         t_in = '1;
      end else begin
         t_in = in_div.q;
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         acc[i] = (68'(psum_ff[i]) <<< FRAC_BITS) + 68'(prod_ff[i]);
         sh[i]  = acc[i] >>> (FRAC_BITS + 1);
         if (!sh[i][67] && (sh[i][66:31] != '0)) begin
            pt[i] = 32'h7FFF_FFFF;
         end else if (sh[i][67] && (sh[i][66:31] != '1)) begin
            pt[i] = 32'h8000_0000;
         end else begin
            pt[i] = sh[i][31:0];
         end
      end
      rsp_in.found         = found_ff;
      rsp_in.approach_time = found_ff ? t_ff : '0;
      rsp_in.point_x       = found_ff ? pt[0] : '0;
      rsp_in.point_y       = found_ff ? pt[1] : '0;
      rsp_in.point_z       = found_ff ? pt[2] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t_ff     <= t_in;
         found_ff <= t_in != '0;
         psum_ff  <= in_ctx.psum;
         for (int i = 0; i < 3; i++) begin
            prod_ff[i] <= $signed(in_ctx.vsum[i]) * $signed({1'b0, t_in});
         end
         rsp_ff <= rsp_in;
      end
   end

   assign out_valid = v2_ff;
   assign out_rsp   = rsp_ff;

endmodule

// File: rtl/closest_approach_point.sv
// Top level of the closest approach point pipeline.
// Closest point of approach of two bodies given as signed fixed-point positions and
// velocities. The pipeline takes one pair per cycle when the result side does not
// stall and passes each result through four front stages (differences, dot products,
// sums, division setup), one restoring-division stage for each of the 32 quotient
// bits, and two back stages for the midpoint. A stall on the result side holds the
// whole pipeline. The threshold register may be written only while no pair is in
// flight.
module closest_approach_point import cap_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  cap_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output cap_rsp_type rsp_data,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data
);

   logic        en;
   logic [31:0] thr_ff;
   logic        dv_valid [QW+1];
   cap_div_type dv_div   [QW+1];
   cap_ctx_type dv_ctx   [QW+1];

   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
      end else if (csr_wr_en) begin
         thr_ff <= csr_wr_data;
      end
   end

   cap_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_valid && req_ready),
      .in_data  (req_data),
      .thr      (thr_ff),
      .out_valid(dv_valid[0]),
      .out_div  (dv_div[0]),
      .out_ctx  (dv_ctx[0])
   );

   for (genvar k = 0; k < QW; k++) begin : g_div
      cap_div_stage #(.BIT(QW - 1 - k)) u_stage (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .in_valid (dv_valid[k]),
         .in_div   (dv_div[k]),
         .in_ctx   (dv_ctx[k]),
         .out_valid(dv_valid[k+1]),
         .out_div  (dv_div[k+1]),
         .out_ctx  (dv_ctx[k+1])
      );
   end

   cap_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (dv_valid[QW]),
      .in_div   (dv_div[QW]),
      .in_ctx   (dv_ctx[QW]),
      .out_valid(rsp_valid),
      .out_rsp  (rsp_data)
   );

   // A reported approach always carries a nonzero time.
   a_found_time: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.found |-> rsp_data.approach_time != '0)
      else $error("found set with zero approach time");

   // Without an approach every other field is zero.
   a_none_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.found |-> rsp_data.approach_time == '0 &&
      rsp_data.point_x == '0 && rsp_data.point_y == '0 && rsp_data.point_z == '0)
      else $error("nonzero fields without an approach");

   // Reset empties the pipeline.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

// File: test/tb_top.sv
// Testbench for the closest approach point pipeline: random and directed body pairs.
`timescale 1ns / 1ps

module tb_top;
   import cap_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   cap_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   cap_rsp_type rsp_data;
   logic        csr_wr_en = 1'b0;
   logic [31:0] csr_wr_data = '0;

   int  pairs_sent = 0;
   int  found_seen = 0;
   bit  quiet_mode = 0;

   always #10 clock = ~clock;

   closest_approach_point dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   class approach_board;
      logic [31:0] speed_floor = THR_RESET;
      cap_rsp_type pending[$];
      int          errors = 0;

      // Exact 128-bit arithmetic; only the quotient and midpoints are rounded.
      function cap_rsp_type predict(cap_req_type r);
         logic signed [127:0] pa[3], va[3], pb[3], vb[3];
         logic signed [127:0] dvdv, dpdv, num, mid, dp, dv;
         logic [127:0] rem, den;
         logic [31:0] t;
         cap_rsp_type o;
         pa[0] = r.pos_a_x; pa[1] = r.pos_a_y; pa[2] = r.pos_a_z;
         va[0] = r.vel_a_x; va[1] = r.vel_a_y; va[2] = r.vel_a_z;
         pb[0] = r.pos_b_x; pb[1] = r.pos_b_y; pb[2] = r.pos_b_z;
         vb[0] = r.vel_b_x; vb[1] = r.vel_b_y; vb[2] = r.vel_b_z;
         o = '0;
         dvdv = 0;
         dpdv = 0;
         for (int i = 0; i < 3; i++) begin
            dp = pa[i] - pb[i];
            dv = va[i] - vb[i];
            dvdv += dv * dv;
            dpdv += dp * dv;
         end
         if (dvdv < $signed({96'd0, speed_floor}) || dpdv >= 0 || dvdv == 0)
            return o;
         num = (-dpdv) <<< 16;
         den = dvdv;
         if (num >= (den << 32)) begin
            t = '1;
         end else begin
            rem = num;
            t = '0;
            for (int i = 31; i >= 0; i--) begin
               if (rem >= (den << i)) begin
                  rem -= den << i;
                  t[i] = 1'b1;
               end
            end
         end
         if (t == 0) return o;
         o.found = 1'b1;
         o.approach_time = t;
         for (int i = 0; i < 3; i++) begin
            mid = ((pa[i] <<< 16) + va[i] * $signed({96'd0, t})
                 + (pb[i] <<< 16) + vb[i] * $signed({96'd0, t})) >>> 17;
            if (mid > 128'sd2147483647) mid = 128'sd2147483647;
            else if (mid < -128'sd2147483648) mid = -128'sd2147483648;
            if (i == 0) o.point_x = mid[31:0];
            else if (i == 1) o.point_y = mid[31:0];
            else o.point_z = mid[31:0];
         end
         return o;
      endfunction

      function void note_pair(cap_req_type r);
         pending.push_back(predict(r));
      endfunction

      function void check_result(cap_rsp_type got);
         cap_rsp_type e;
         if (pending.size() == 0) begin
            $error("result with nothing expected");
            errors++;
            return;
         end
         e = pending.pop_front();
         if (got.found !== e.found) begin
            $error("found exp %0d got %0d", e.found, got.found); errors++;
         end
         if (got.approach_time !== e.approach_time) begin
            $error("approach_time exp %h got %h", e.approach_time, got.approach_time);
            errors++;
         end
         if (got.point_x !== e.point_x) begin
            $error("point_x exp %h got %h", e.point_x, got.point_x); errors++;
         end
         if (got.point_y !== e.point_y) begin
            $error("point_y exp %h got %h", e.point_y, got.point_y); errors++;
         end
         if (got.point_z !== e.point_z) begin
            $error("point_z exp %h got %h", e.point_z, got.point_z); errors++;
         end
      endfunction
   endclass

   approach_board board = new();

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         board.check_result(rsp_data);
         if (rsp_data.found) found_seen++;
      end
      if (!reset) rsp_ready <= quiet_mode || ($urandom_range(99) >= 28);
   end

   function automatic logic [31:0] rnd_word();
      case ($urandom_range(5))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return $urandom_range(65535) << 8;
         3: return -($urandom_range(65535) << 8);
         default: return $urandom();
      endcase
   endfunction

   // Small vectors around a common origin make real approaches likely.
   function automatic cap_req_type rnd_pair();
      cap_req_type r;
      logic [31:0] base;
      r = '0;
      if ($urandom_range(3) == 0) begin
         for (int i = 0; i < 12; i++) r[i*32 +: 32] = rnd_word();
      end else begin
         base = $urandom();
         for (int i = 0; i < 12; i++)
            r[i*32 +: 32] = ((i % 6) < 3 ? base : 32'd0)
                            + $signed(32'($urandom_range(2**20) - 2**19)) * 32'd16;
      end
      return r;
   endfunction

   // Valid stays high across back-to-back transfers and drops only for idle cycles.
   task automatic send_pair(cap_req_type r);
      if (!quiet_mode)
         while ($urandom_range(99) < 28) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      board.note_pair(r);
      pairs_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   task automatic write_floor(logic [31:0] v);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      board.speed_floor = v;
   endtask

   initial begin
      cap_req_type r;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Head-on pair, receding pair, zero motion, extremes, tiny and huge times.
      r = '0; r.pos_a_x = 32'sd10 <<< 16; r.vel_a_x = -(32'sd1 <<< 16);
      send_pair(r);
      r.vel_a_x = 32'sd1 <<< 16; send_pair(r);
      r = '0; send_pair(r);
      r = '0; r.pos_a_x = 32'sd1; r.vel_a_x = -32'sh7FFF_FFFF; r.vel_b_x = 32'sh7FFF_FFFF;
      send_pair(r);
      r = '0; r.pos_a_y = 32'sh7FFF_FFFF; r.pos_b_y = 32'sh8000_0000; r.vel_a_y = -32'sd100;
      send_pair(r);
      r = '0; r.pos_a_z = 32'sh8000_0000; r.vel_a_z = 32'sh7FFF_FFFF;
      r.vel_b_x = 32'sh8000_0000; r.pos_b_x = 32'sh7FFF_FFFF; send_pair(r);
      for (int i = 0; i < 12; i++) begin
         r = '1; r[i*32 +: 32] = 32'h8000_0000; send_pair(r);
         r = '0; r[i*32 +: 32] = 32'h7FFF_FFFF; send_pair(r);
      end
      drain();

      write_floor(32'd0);
      r = '0; r.pos_a_x = 32'sd5; send_pair(r);
      r.vel_a_x = -32'sd1; send_pair(r);
      for (int i = 0; i < 200; i++) send_pair(rnd_pair());
      // Hold the sender until the pipeline is empty.
      drain();

      write_floor(32'hFFFF_FFFF);
      for (int i = 0; i < 150; i++) send_pair(rnd_pair());
      drain();

      write_floor(THR_RESET);
      quiet_mode = 1;
      for (int i = 0; i < 200; i++) send_pair(rnd_pair());
      quiet_mode = 0;
      for (int i = 0; i < 350; i++) send_pair(rnd_pair());
      drain();

      write_floor($urandom());
      for (int i = 0; i < 50; i++) send_pair(rnd_pair());
      drain();

      $display("Sent %0d body pairs over five threshold settings; %0d approaches found.",
               pairs_sent, found_seen);
      if (board.errors == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   initial begin
      #5ms;
      $display("simulation failed");
      $finish;
   end
endmodule

// File: filelist.f
rtl/cap_pkg.sv
rtl/cap_front.sv
rtl/cap_div_stage.sv
rtl/cap_back.sv
rtl/closest_approach_point.sv
test/tb_top.sv
